// ----- rtl/escaped_frame_crc16_checker_macros.svh -----
// ----------------------------------------------------------------------------
// escaped_frame_crc16_checker assertion macros
// Shared concurrent assertion forms for the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_CRC16_CHECKER_MACROS_SVH
`define ESCAPED_FRAME_CRC16_CHECKER_MACROS_SVH

// same-cycle implication, held off during reset
`define EFCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define EFCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/efcc_pkg.sv -----
// ----------------------------------------------------------------------------
// efcc_pkg
// Types, constants and the crc and unescape helpers for the escaped frame crc16 checker.
// ----------------------------------------------------------------------------
package efcc_pkg;

   localparam int HEADER_BYTES_DEF = 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0]  ESC_CHAR   = 8'h7d;
   localparam logic [7:0]  ESC_CODE_1 = 8'h01;
   localparam logic [7:0]  ESC_CODE_2 = 8'h02;
   localparam logic [7:0]  ESC_CODE_3 = 8'h03;
   localparam logic [7:0]  ESC_VAL_1  = 8'h7d;
   localparam logic [7:0]  ESC_VAL_2  = 8'h7f;
   localparam logic [7:0]  ESC_VAL_3  = 8'h7e;
   localparam logic [15:0] CRC_INIT   = 16'hffff;
   localparam logic [15:0] CRC_POLY   = 16'ha001;
   localparam logic [7:0]  COUNT_MAX  = 8'hff;
   localparam logic [7:0]  MAX_LEN_RESET = 8'hff;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE  = 1'b0,
      CSR_MAX_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_CRC_ERR  = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_DISABLED = 3'd3,
      ST_TRUNC    = 3'd4
   } status_type;

   // reflected crc16 over one byte, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] code);
      logic [7:0] val;
      unique case (code)
         ESC_CODE_1: val = ESC_VAL_1;
         ESC_CODE_2: val = ESC_VAL_2;
         ESC_CODE_3: val = ESC_VAL_3;
         default:    val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/efcc_channels.sv -----
// ----------------------------------------------------------------------------
// efcc channels
// Valid/ready channels for raw frame bytes and decoded results.
// ----------------------------------------------------------------------------
interface efcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic       last;

   modport source (output valid, output raw_byte, output last, input ready);
   modport sink   (input valid, input raw_byte, input last, output ready);
endinterface

interface efcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        data_valid;
   logic        frame_done;
   logic [2:0]  status;
   logic [15:0] received_crc;
   logic [15:0] body_length;

   modport source (output valid, output data_byte, output data_valid,
                   output frame_done, output status, output received_crc,
                   output body_length, input ready);
   modport sink   (input valid, input data_byte, input data_valid,
                   input frame_done, input status, input received_crc,
                   input body_length, output ready);
endinterface

// ----- rtl/escaped_frame_crc16_checker.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_crc16_checker
// Removes 0x7d escapes from a raw byte stream, passes decoded bytes out,
// checks the crc16 (modbus) of each frame and reports a status on its last byte.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | raw_byte, last
//   rsp     | out | valid/ready  | data_byte, data_valid, frame_done, status,
//           |     |              | received_crc, body_length
//   csr     | in  | csr_we       | csr_index, csr_wdata
//
// one raw byte per cycle unless rsp stalls; a taken byte reaches rsp after passing
// through the input register, then the result register
// the one-byte crc update plus the unescape step sit between the two registers
// a lone escape byte that is not last produces no transaction
// rsp stalls back up through the input register one stage at a time
// synchronous reset: enable 0, max_frame_len 255, frame state cleared
// ----------------------------------------------------------------------------
module escaped_frame_crc16_checker #(
   parameter int HEADER_BYTES = efcc_pkg::HEADER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   efcc_req_if.sink                         req_chan,
   efcc_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [efcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [efcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import efcc_pkg::*;

   `include "escaped_frame_crc16_checker_macros.svh"

   localparam int POS_W = 18;

   // configuration
   logic        enable_ff;
   logic [7:0]  max_len_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // frame state
   logic [7:0]  raw_cnt_ff, raw_cnt_in;
   logic [7:0]  dec_idx_ff, dec_idx_in;
   logic        esc_ff, esc_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] cap_ff, cap_in;
   logic        overlen_ff, overlen_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff;
   logic        out_dvalid_ff;
   logic        out_done_ff;
   status_type  out_status_ff;
   logic [15:0] out_crc_ff;
   logic [15:0] out_len_ff;

   logic        advance;
   logic        have;
   logic [7:0]  dec_byte;
   logic        use_byte;
   logic [POS_W-1:0] end_pos;
   logic [POS_W-1:0] idx_ext;
   logic [POS_W-1:0] need_cnt;
   logic [7:0]  raw_next;
   logic [7:0]  dec_next;
   logic        esc_next;
   logic [15:0] len_next;
   logic [15:0] crc_next;
   logic [15:0] cap_next;
   logic        overlen_next;
   status_type  status_val;
   logic        produce;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            CSR_MAX_LEN: max_len_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.raw_byte;
         in_last_ff <= req_chan.last;
      end
   end

   // decode, length, crc and capture for the byte in the input register
   always_comb begin
      raw_next     = (raw_cnt_ff != COUNT_MAX) ? raw_cnt_ff + 8'd1 : COUNT_MAX;
      overlen_next = overlen_ff || (raw_next >= max_len_ff);

      have     = 1'b1;
      dec_byte = in_byte_ff;
      esc_next = 1'b0;
      if (esc_ff) begin
         dec_byte = unescape(in_byte_ff);
      end else if (in_byte_ff == ESC_CHAR) begin
         have     = 1'b0;
         dec_byte = 8'h00;
         esc_next = 1'b1;
      end

      use_byte = have && (dec_idx_ff != COUNT_MAX);
      idx_ext  = POS_W'(dec_idx_ff);

      len_next = len_ff;
      if (use_byte && dec_idx_ff == 8'd1) begin
         len_next = {dec_byte, len_ff[7:0]};
      end else if (use_byte && dec_idx_ff == 8'd2) begin
         len_next = {len_ff[15:8], dec_byte};
      end

      end_pos = POS_W'(HEADER_BYTES) + POS_W'(len_next);

      crc_next = crc_ff;
      if (use_byte && dec_idx_ff != 8'd0 && idx_ext < end_pos) begin
         crc_next = crc16_byte(crc_ff, dec_byte);
      end

      cap_next = cap_ff;
      if (use_byte && idx_ext == end_pos) begin
         cap_next = {dec_byte, cap_ff[7:0]};
      end else if (use_byte && idx_ext == end_pos + POS_W'(1)) begin
         cap_next = {cap_ff[15:8], dec_byte};
      end

      dec_next = use_byte ? dec_idx_ff + 8'd1 : dec_idx_ff;
      need_cnt = end_pos + POS_W'(2);

      priority if (!enable_ff) begin
         status_val = ST_DISABLED;
      end else if (overlen_next) begin
         status_val = ST_TOO_LONG;
      end else if (esc_next || POS_W'(dec_next) < need_cnt) begin
         status_val = ST_TRUNC;
      end else if (crc_next != cap_next) begin
         status_val = ST_CRC_ERR;
      end else begin
         status_val = ST_OK;
      end

      produce = have || in_last_ff;
   end

   // frame state clears after the last byte
   always_comb begin
      raw_cnt_in = raw_cnt_ff;
      dec_idx_in = dec_idx_ff;
      esc_in     = esc_ff;
      crc_in     = crc_ff;
      len_in     = len_ff;
      cap_in     = cap_ff;
      overlen_in = overlen_ff;
      if (advance) begin
         if (in_last_ff) begin
            raw_cnt_in = 8'd0;
            dec_idx_in = 8'd0;
            esc_in     = 1'b0;
            crc_in     = CRC_INIT;
            len_in     = 16'd0;
            cap_in     = 16'd0;
            overlen_in = 1'b0;
         end else begin
            raw_cnt_in = raw_next;
            dec_idx_in = dec_next;
            esc_in     = esc_next;
            crc_in     = crc_next;
            len_in     = len_next;
            cap_in     = cap_next;
            overlen_in = overlen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_cnt_ff <= 8'd0;
         dec_idx_ff <= 8'd0;
         esc_ff     <= 1'b0;
         crc_ff     <= CRC_INIT;
         len_ff     <= 16'd0;
         cap_ff     <= 16'd0;
         overlen_ff <= 1'b0;
      end else begin
         raw_cnt_ff <= raw_cnt_in;
         dec_idx_ff <= dec_idx_in;
         esc_ff     <= esc_in;
         crc_ff     <= crc_in;
         len_ff     <= len_in;
         cap_ff     <= cap_in;
         overlen_ff <= overlen_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = produce;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff   <= dec_byte;
         out_dvalid_ff <= have;
         out_done_ff   <= in_last_ff;
         out_status_ff <= in_last_ff ? status_val : ST_OK;
         out_crc_ff    <= in_last_ff ? cap_next : 16'd0;
         out_len_ff    <= in_last_ff ? len_next : 16'd0;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.data_byte    = out_data_ff;
   assign rsp_chan.data_valid   = out_dvalid_ff;
   assign rsp_chan.frame_done   = out_done_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.received_crc = out_crc_ff;
   assign rsp_chan.body_length  = out_len_ff;

   `EFCC_ASSERT_NEXT(a_clear_after_last, clock, reset, advance && in_last_ff,
      raw_cnt_ff == 8'd0 && dec_idx_ff == 8'd0 && !esc_ff && crc_ff == CRC_INIT,
      "frame state not cleared after last byte")
   `EFCC_ASSERT_NOW(a_idx_le_raw, clock, reset, 1'b1, dec_idx_ff <= raw_cnt_ff,
      "decoded index ahead of raw count")
   `EFCC_ASSERT_NOW(a_quiet_fields, clock, reset, out_valid_ff && !out_done_ff,
      out_status_ff == ST_OK && out_crc_ff == 16'd0 && out_len_ff == 16'd0,
      "frame fields set on a transaction that does not end a frame")
   `EFCC_ASSERT_NOW(a_data_zero, clock, reset, out_valid_ff && !out_dvalid_ff,
      out_data_ff == 8'h00, "data byte set without a decoded byte")

endmodule
